>>> rtl/bng_pkg.sv
// ----------------------------------------------------------------------------
// bng_pkg
// Shared types and constants of the bond network gradient unit.
// ----------------------------------------------------------------------------
package bng_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BOND  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_RD_ADDR,
		S_RD_OUT,
		S_PA_RD,
		S_PB_RD,
		S_V_CALC,
		S_SQ_MUL,
		S_SQ_ACC,
		S_SQRT,
		S_LCHK,
		S_DIV,
		S_F_CALC,
		S_T_LO,
		S_T_HI,
		S_T_ACC,
		S_T_SAT,
		S_G_LO,
		S_G_HI,
		S_G_ACC,
		S_G_SAT,
		S_GA_RD,
		S_GA_WR,
		S_GB_RD,
		S_GB_WR
	} state_t;

	localparam logic [1:0] AXIS_NONE = 2'd3;
	localparam logic [1:0] AXIS_LAST = 2'd2;
	localparam logic [5:0] SQRT_LAST = 6'd33;
	localparam logic [5:0] DIV_LAST  = 6'd47;
	localparam logic [47:0] ONE_Q16  = 48'h0000_0001_0000;
	localparam int PART_SHIFT = 24;

endpackage

>>> rtl/bng_ram.sv
// ----------------------------------------------------------------------------
// bng_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bng_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/bond_network_gradient_unit.sv
// ----------------------------------------------------------------------------
// bond_network_gradient_unit
// Harmonic bond network gradient accumulator in Q16.16 / Q32.16 fixed point.
// ----------------------------------------------------------------------------
// One item is handled at a time and the input is stalled while it runs. A
// coordinate load is written straight from the input beat, a gradient read
// waits out any output stall, and a clear sweeps all ATOMS*3 gradient
// slots; after reset the gradient store is swept to zero before the first
// beat is taken. A bond runs the bit-pair square root and
// the restoring divider, both on one shared remainder register, plus the
// steps that reuse the single 33x33 multiplier and the gradient memory port.
module bond_network_gradient_unit #(
	parameter int ATOMS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [3:0]         atom_a,
	input  logic [3:0]         atom_b,
	input  logic [1:0]         axis,
	input  logic signed [31:0] coordinate,
	input  logic [31:0]        rest_length,
	input  logic [31:0]        stiffness,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] gradient_value,
	output logic               degenerate_seen
);
	import bng_pkg::*;

	localparam int SLOTS = ATOMS * 3;
	localparam int SW = $clog2(SLOTS);

	function automatic logic [SW-1:0] slot_of(input logic [3:0] atom, input logic [1:0] ax);
		logic [6:0] s;
		s = {2'b0, atom, 1'b0} + {3'b0, atom} + {5'b0, ax};
		return SW'(s);
	endfunction

	function automatic logic atom_ok(input logic [3:0] atom);
		return {28'b0, atom} < 32'(ATOMS);
	endfunction

	function automatic logic [47:0] sat_add(input logic [47:0] x, input logic [47:0] y);
		logic [48:0] s;
		s = {x[47], x} + {y[47], y};
		if (s[48] != s[47]) begin
			return s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		end
		return s[47:0];
	endfunction

	function automatic logic [47:0] sat_sub(input logic [47:0] x, input logic [47:0] y);
		logic [48:0] s;
		s = {x[47], x} - {y[47], y};
		if (s[48] != s[47]) begin
			return s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		end
		return s[47:0];
	endfunction

	state_t state_q, state_d;
	logic [1:0] ax_q;
	logic [5:0] it_q;
	logic [SW-1:0] clr_q;
	logic flag_q;
	logic ov_q;
	logic [47:0] gv_q;
	logic df_q;

	logic [3:0] a_q, b_q;
	logic [1:0] axis_q;
	logic rd_ok_q;
	logic [31:0] d_q, k_q;
	logic [31:0] pa_q;
	logic [32:0] vmag_q [3];
	logic vneg_q [3];
	logic [65:0] prod_q;
	logic [80:0] acc_q;
	logic [35:0] rem_q;
	logic [33:0] root_q;
	logic [48:0] fm_q;
	logic fneg_q;
	logic [47:0] tmag_q;
	logic tneg_q;
	logic [47:0] g_q;

	logic accept;
	logic [32:0] mul_a, mul_b;

	logic pos_we;
	logic [SW-1:0] pos_waddr, pos_raddr;
	logic [31:0] pos_rdata;
	logic grd_we;
	logic [SW-1:0] grd_waddr, grd_raddr;
	logic [47:0] grd_wdata, grd_rdata;

	// Square root and divider steps.
	logic [35:0] sq_rem, sq_trial;
	logic sq_ge;
	logic [34:0] dv_rem;
	logic dv_ge;

	// Saturation of the scaled products.
	logic [65:0] t_p, t_lim;
	logic [47:0] t_m;
	logic [64:0] g_p, g_lim;
	logic g_neg;
	logic [47:0] g_m;
	logic [32:0] v_diff;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign sq_rem = {rem_q[33:0], acc_q[67:66]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge = (sq_rem >= sq_trial);
	assign dv_rem = {rem_q[33:0], acc_q[47]};
	assign dv_ge = (dv_rem >= {1'b0, root_q});

	assign v_diff = {pa_q[31], pa_q} - {pos_rdata[31], pos_rdata};

	assign t_p = acc_q[80:15];
	assign t_lim = fneg_q ? 66'(48'h8000_0000_0000) : 66'(48'h7FFF_FFFF_FFFF);
	assign t_m = (t_p > t_lim) ? t_lim[47:0] : t_p[47:0];

	assign g_p = acc_q[80:16];
	assign g_neg = (vneg_q[ax_q] != tneg_q);
	assign g_lim = g_neg ? 65'(48'h8000_0000_0000) : 65'(48'h7FFF_FFFF_FFFF);
	assign g_m = (g_p > g_lim) ? g_lim[47:0] : g_p[47:0];

	always_comb begin
		mul_a = vmag_q[ax_q];
		mul_b = vmag_q[ax_q];
		unique case (state_q)
			S_T_LO: begin
				mul_a = {1'b0, k_q};
				mul_b = {9'b0, fm_q[23:0]};
			end
			S_T_HI: begin
				mul_a = {1'b0, k_q};
				mul_b = {8'b0, fm_q[48:24]};
			end
			S_G_LO: mul_b = {9'b0, tmag_q[23:0]};
			S_G_HI: mul_b = {9'b0, tmag_q[47:24]};
			default: ;
		endcase
	end

	assign pos_we = accept && (command == CMD_LOAD) && atom_ok(atom_a) && (axis != AXIS_NONE);
	assign pos_waddr = slot_of(atom_a, axis);
	assign pos_raddr = (state_q == S_PB_RD) ? slot_of(b_q, ax_q) : slot_of(a_q, ax_q);

	always_comb begin
		grd_we = 1'b0;
		grd_waddr = clr_q;
		grd_wdata = '0;
		grd_raddr = slot_of(a_q, axis_q);
		unique case (state_q)
			S_CLR: grd_we = 1'b1;
			S_GA_RD: grd_raddr = slot_of(a_q, ax_q);
			S_GA_WR: begin
				grd_we = 1'b1;
				grd_waddr = slot_of(a_q, ax_q);
				grd_wdata = sat_add(grd_rdata, g_q);
			end
			S_GB_RD: grd_raddr = slot_of(b_q, ax_q);
			S_GB_WR: begin
				grd_we = 1'b1;
				grd_waddr = slot_of(b_q, ax_q);
				grd_wdata = sat_sub(grd_rdata, g_q);
			end
			default: ;
		endcase
	end

	bng_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_pos (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(coordinate),
		.raddr(pos_raddr), .rdata(pos_rdata)
	);

	bng_ram #(.WIDTH(48), .DEPTH(SLOTS)) u_grad (
		.clk(clk), .we(grd_we), .waddr(grd_waddr), .wdata(grd_wdata),
		.raddr(grd_raddr), .rdata(grd_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_LOAD: state_d = S_IDLE;
						CMD_BOND: state_d = (atom_ok(atom_a) && atom_ok(atom_b)) ? S_PA_RD : S_IDLE;
						CMD_READ: state_d = S_RD_ADDR;
						CMD_CLEAR: state_d = S_CLR;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CLR: if (clr_q == SW'(SLOTS - 1)) state_d = S_IDLE;
			S_RD_ADDR: state_d = S_RD_OUT;
			S_RD_OUT: if (!ov_q || !out_stall) state_d = S_IDLE;
			S_PA_RD: state_d = S_PB_RD;
			S_PB_RD: state_d = S_V_CALC;
			S_V_CALC: state_d = (ax_q == AXIS_LAST) ? S_SQ_MUL : S_PA_RD;
			S_SQ_MUL: state_d = S_SQ_ACC;
			S_SQ_ACC: state_d = (ax_q == AXIS_LAST) ? S_SQRT : S_SQ_MUL;
			S_SQRT: if (it_q == SQRT_LAST) state_d = S_LCHK;
			S_LCHK: state_d = (root_q == '0) ? S_IDLE : S_DIV;
			S_DIV: if (it_q == DIV_LAST) state_d = S_F_CALC;
			S_F_CALC: state_d = S_T_LO;
			S_T_LO: state_d = S_T_HI;
			S_T_HI: state_d = S_T_ACC;
			S_T_ACC: state_d = S_T_SAT;
			S_T_SAT: state_d = S_G_LO;
			S_G_LO: state_d = S_G_HI;
			S_G_HI: state_d = S_G_ACC;
			S_G_ACC: state_d = S_G_SAT;
			S_G_SAT: state_d = S_GA_RD;
			S_GA_RD: state_d = S_GA_WR;
			S_GA_WR: state_d = S_GB_RD;
			S_GB_RD: state_d = S_GB_WR;
			S_GB_WR: state_d = (ax_q == AXIS_LAST) ? S_IDLE : S_G_LO;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters, the sticky flag and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			it_q <= '0;
			clr_q <= '0;
			flag_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (state_q == S_RD_OUT && (!ov_q || !out_stall)) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					ax_q <= '0;
					clr_q <= '0;
					if (accept && command == CMD_CLEAR) flag_q <= 1'b0;
				end
				S_CLR: clr_q <= clr_q + 1'b1;
				S_V_CALC, S_SQ_ACC: begin
					ax_q <= (ax_q == AXIS_LAST) ? 2'd0 : ax_q + 1'b1;
					it_q <= '0;
				end
				S_SQRT, S_DIV: it_q <= it_q + 1'b1;
				S_LCHK: begin
					it_q <= '0;
					if (root_q == '0) flag_q <= 1'b1;
				end
				S_T_SAT: ax_q <= '0;
				S_GB_WR: ax_q <= (ax_q == AXIS_LAST) ? 2'd0 : ax_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				a_q <= atom_a;
				b_q <= atom_b;
				axis_q <= axis;
				d_q <= rest_length;
				k_q <= stiffness;
				rd_ok_q <= atom_ok(atom_a) && (axis != AXIS_NONE);
				acc_q <= '0;
			end
			S_RD_OUT: begin
				if (!ov_q || !out_stall) begin
					gv_q <= rd_ok_q ? grd_rdata : '0;
					df_q <= flag_q;
				end
			end
			S_PB_RD: pa_q <= pos_rdata;
			S_V_CALC: begin
				vneg_q[ax_q] <= v_diff[32];
				vmag_q[ax_q] <= v_diff[32] ? 33'(-v_diff) : v_diff;
			end
			S_SQ_ACC: begin
				acc_q <= acc_q + 81'(prod_q);
				rem_q <= '0;
				root_q <= '0;
			end
			S_SQRT: begin
				// Bit-pair square root: two radicand bits enter the remainder each step.
				acc_q <= acc_q << 2;
				rem_q <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
				root_q <= {root_q[32:0], sq_ge};
			end
			S_LCHK: begin
				rem_q <= '0;
				acc_q <= {33'b0, d_q, 16'b0};
			end
			S_DIV: begin
				// Restoring division; quotient bits shift in as dividend bits leave.
				rem_q <= 36'(dv_ge ? (dv_rem - {1'b0, root_q}) : dv_rem);
				acc_q[47:0] <= {acc_q[46:0], dv_ge};
			end
			S_F_CALC: begin
				fneg_q <= (acc_q[47:0] > ONE_Q16);
				fm_q <= (acc_q[47:0] > ONE_Q16) ? ({1'b0, acc_q[47:0]} - {1'b0, ONE_Q16})
					: ({1'b0, ONE_Q16} - {1'b0, acc_q[47:0]});
			end
			S_T_HI, S_G_HI: acc_q <= 81'(prod_q);
			S_T_ACC, S_G_ACC: acc_q <= acc_q + (81'(prod_q) << PART_SHIFT);
			S_T_SAT: begin
				tmag_q <= t_m;
				tneg_q <= fneg_q && (t_m != '0);
			end
			S_G_SAT: g_q <= g_neg ? 48'(-g_m) : g_m;
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign gradient_value = gv_q;
	assign degenerate_seen = df_q;

	a_read_path: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_READ) |=> (state_q == S_RD_ADDR))
		else $error("read beat did not start the read sequence");

	a_flag_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(flag_q) |-> ($past(state_q) == S_LCHK))
		else $error("degenerate flag set outside the length check");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> ($past(state_q) == S_RD_OUT))
		else $error("result beat raised without a read");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (root_q != '0))
		else $error("division entered with zero bond length");

endmodule
